### rtl/edge_capture_pulse_queue_defines.svh
// Assertion macros for the edge capture pulse queue.
`ifndef EDGE_CAPTURE_PULSE_QUEUE_DEFINES_SVH
`define EDGE_CAPTURE_PULSE_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define ECPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ECPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ECPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define ECPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/ecpq_pkg.sv
// Shared constants, types and structs of the edge capture pulse queue.
package ecpq_pkg;

    localparam int CHANNELS    = 2;
    localparam int QUEUE_DEPTH = 64;

    localparam int TIMER_W  = 16;
    localparam int LENGTH_W = 15;
    localparam int ENTRY_W  = LENGTH_W + 1;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W   = CH_W + PTR_W;

    localparam logic [LENGTH_W-1:0] LENGTH_MAX = 15'h7fff;

    typedef enum logic
    {
        CMD_CAPTURE = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic               channel;
        logic [TIMER_W-1:0] capture_value;
    } item_t;

    typedef struct packed
    {
        logic               wr_en;
        logic               rd_en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] wr_data;
    } store_req_t;

    typedef struct packed
    {
        logic             strobe;
        logic             valid;
        logic [CNT_W-1:0] count;
    } result_ctl_t;

endpackage

### rtl/ecpq_store.sv
// Pulse store memory: one write or one registered read per cycle.
module ecpq_store
(
    input  logic                        clk,
    input  ecpq_pkg::store_req_t        req,
    output logic [ecpq_pkg::ENTRY_W-1:0] rd_data
);
    import ecpq_pkg::*;

    logic [ENTRY_W-1:0] mem [2**ADDR_W];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ecpq_ctrl.sv
// Per-channel capture state, queue pointers and result control.
module ecpq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  ecpq_pkg::item_t       item,
    output ecpq_pkg::store_req_t  store_req,
    output ecpq_pkg::result_ctl_t res
);
    import ecpq_pkg::*;

    logic [TIMER_W-1:0] prev_capture_reg  [CHANNELS];
    logic [TIMER_W-1:0] prev_capture_next [CHANNELS];
    logic               level_reg         [CHANNELS];
    logic               level_next        [CHANNELS];
    logic [PTR_W-1:0]   wp_reg            [CHANNELS];
    logic [PTR_W-1:0]   wp_next           [CHANNELS];
    logic [PTR_W-1:0]   rp_reg            [CHANNELS];
    logic [PTR_W-1:0]   rp_next           [CHANNELS];
    logic [CNT_W-1:0]   fill_reg          [CHANNELS];
    logic [CNT_W-1:0]   fill_next         [CHANNELS];

    result_ctl_t res_reg;
    result_ctl_t res_next;

    logic [CH_W-1:0]     ch_idx;
    logic                in_range;
    logic [TIMER_W-1:0]  diff;
    logic [LENGTH_W-1:0] length;
    logic                full;
    logic                empty;
    logic                do_capture;
    logic                do_push;
    logic                do_pop;
    logic [PTR_W-1:0]    wp;
    logic [PTR_W-1:0]    rp;
    logic [CNT_W-1:0]    count_after;

    assign ch_idx   = CH_W'(item.channel);
    assign in_range = 32'(item.channel) < CHANNELS;

    assign wp    = wp_reg[ch_idx];
    assign rp    = rp_reg[ch_idx];
    assign full  = fill_reg[ch_idx] == CNT_W'(QUEUE_DEPTH);
    assign empty = fill_reg[ch_idx] == '0;

    // Wrap modulo 2^16, then clamp anything past 15 bits
    assign diff   = item.capture_value - prev_capture_reg[ch_idx];
    assign length = diff[TIMER_W-1] ? LENGTH_MAX : diff[LENGTH_W-1:0];

    assign do_capture = item_valid && in_range && item.cmd == CMD_CAPTURE;
    assign do_push    = do_capture && !full;
    assign do_pop     = item_valid && in_range && item.cmd == CMD_READ && !empty;

    assign count_after = fill_reg[ch_idx] + CNT_W'(do_push) - CNT_W'(do_pop);

    always_comb
    begin
        store_req.wr_en   = do_push;
        store_req.rd_en   = do_pop;
        store_req.addr    = do_push ? {ch_idx, wp} : {ch_idx, rp};
        store_req.wr_data = {level_reg[ch_idx], length};
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            prev_capture_next[c] = prev_capture_reg[c];
            level_next[c]        = level_reg[c];
            wp_next[c]           = wp_reg[c];
            rp_next[c]           = rp_reg[c];
            fill_next[c]         = fill_reg[c];
        end
        if (do_capture)
        begin
            prev_capture_next[ch_idx] = item.capture_value;
            level_next[ch_idx]        = !level_reg[ch_idx];
        end
        if (do_push)
        begin
            wp_next[ch_idx] = (wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
        end
        if (do_pop)
        begin
            rp_next[ch_idx] = (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
        end
        fill_next[ch_idx] = count_after;

        res_next.strobe = item_valid;
        res_next.valid  = do_pop;
        res_next.count  = in_range ? count_after : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                prev_capture_reg[c] <= '0;
                level_reg[c]        <= 1'b1;
                wp_reg[c]           <= '0;
                rp_reg[c]           <= '0;
                fill_reg[c]         <= '0;
            end
            res_reg <= '0;
        end
        else
        begin
            prev_capture_reg <= prev_capture_next;
            level_reg        <= level_next;
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            fill_reg         <= fill_next;
            res_reg          <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/edge_capture_pulse_queue.sv
// Top level of the edge capture pulse queue.
//
//  channel  | handshake      | signals
//  ---------+----------------+---------------------------------------------------
//  request  | start & !busy  | cmd, channel, capture_value
//  result   | done           | pulse_valid, pulse_length, pulse_level, queue_count
//
// One request per cycle; its result shows on done once it has passed the input register
// and the result register, which loads in the same cycle as the registered read of the pulse store.
// busy stays low: the block never stalls requests.
// Reset returns all channel state to its initial values; the pulse store itself is not cleared.
// The receiver cannot stall; each result is valid for exactly one cycle.
`include "edge_capture_pulse_queue_defines.svh"

module edge_capture_pulse_queue
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic                           channel,
    input  logic [ecpq_pkg::TIMER_W-1:0]   capture_value,
    output logic                           done,
    output logic                           pulse_valid,
    output logic [ecpq_pkg::LENGTH_W-1:0]  pulse_length,
    output logic                           pulse_level,
    output logic [ecpq_pkg::CNT_W-1:0]     queue_count
);
    import ecpq_pkg::*;

    item_t       item_reg;
    logic        item_valid_reg;
    store_req_t  store_req;
    result_ctl_t res;
    logic [ENTRY_W-1:0] rd_data;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    // Hold the request payload for processing in the control stage
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= '{cmd: cmd_t'(cmd), channel: channel, capture_value: capture_value};
        end
    end

    ecpq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .store_req  (store_req),
        .res        (res)
    );

    ecpq_store u_store
    (
        .clk     (clk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign done         = res.strobe;
    assign pulse_valid  = res.valid;
    assign pulse_length = res.valid ? rd_data[LENGTH_W-1:0] : '0;
    assign pulse_level  = res.valid && rd_data[ENTRY_W-1];
    assign queue_count  = res.count;

    `ECPQ_ASSERT_SAME(a_done_follows_start, start && !busy, ##2 done, "result strobe missing")
    `ECPQ_ASSERT_SAME(a_valid_needs_done, pulse_valid, done, "pulse_valid without result strobe")
    `ECPQ_ASSERT_SAME(a_pop_leaves_room, pulse_valid, queue_count < CNT_W'(QUEUE_DEPTH), "count after pop too large")
    `ECPQ_ASSERT_NEXT(a_capture_no_pulse, item_valid_reg && item_reg.cmd == CMD_CAPTURE, !pulse_valid, "capture returned a pulse")

endmodule

### dv/testbench.sv
// Self-checking testbench for the edge capture pulse queue: directed table plus biased random.
`timescale 1ns / 100ps

module testbench;
    import ecpq_pkg::*;

    localparam int NUM_DIR        = 24;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 88;
    localparam int MAX_GAP        = 18;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed
    {
        logic                valid;
        logic [LENGTH_W-1:0] length;
        logic                level;
        logic [CNT_W-1:0]    count;
    } pulse_rec_t;

    typedef struct packed
    {
        item_t      req;
        logic       known;
        pulse_rec_t res;
    } dir_row_t;

    localparam pulse_rec_t NO_CHECK = '0;

    // Expected results are typed in only for empty reads, extremes and simple pops.
    localparam dir_row_t DIR_TAB [NUM_DIR] = '{
        '{'{CMD_READ,    1'b0, 16'h0000}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd0}},
        '{'{CMD_READ,    1'b1, 16'hffff}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd0}},
        '{'{CMD_CAPTURE, 1'b0, 16'h0000}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd1}},
        '{'{CMD_CAPTURE, 1'b0, 16'hffff}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd2}},
        '{'{CMD_CAPTURE, 1'b0, 16'h7fff}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd3}},
        '{'{CMD_CAPTURE, 1'b0, 16'hfffe}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd4}},
        '{'{CMD_CAPTURE, 1'b0, 16'h0003}, 1'b0, NO_CHECK},
        '{'{CMD_CAPTURE, 1'b1, 16'h8000}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd1}},
        '{'{CMD_CAPTURE, 1'b1, 16'h8000}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd2}},
        '{'{CMD_CAPTURE, 1'b1, 16'h5555}, 1'b0, NO_CHECK},
        '{'{CMD_CAPTURE, 1'b1, 16'haaaa}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b0, 16'h0000}, 1'b1, '{1'b1, 15'd0,      1'b1, 7'd4}},
        '{'{CMD_READ,    1'b0, 16'h0000}, 1'b1, '{1'b1, 15'h7fff,   1'b0, 7'd3}},
        '{'{CMD_READ,    1'b0, 16'hffff}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b0, 16'h0000}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b0, 16'h0000}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b0, 16'h0000}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd0}},
        '{'{CMD_READ,    1'b1, 16'ha5a5}, 1'b0, NO_CHECK},
        '{'{CMD_CAPTURE, 1'b0, 16'h1234}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b0, 16'h0000}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b1, 16'h0000}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b1, 16'h0000}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b1, 16'h0000}, 1'b0, NO_CHECK},
        '{'{CMD_READ,    1'b1, 16'h0000}, 1'b1, '{1'b0, 15'd0,      1'b0, 7'd0}}
    };

    // Per phase: percent captures, percent on channel 0, percent of requests preceded by a gap.
    localparam int PHASE_CAP [NUM_PHASES] = '{95, 10, 95, 50, 10, 60, 50, 50};
    localparam int PHASE_CH0 [NUM_PHASES] = '{90, 90, 10, 50, 10, 50, 50, 50};
    localparam int PHASE_GAP [NUM_PHASES] = '{20, 10,  0, 30, 15, 25, 10,  0};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    cmd_t               cmd = CMD_CAPTURE;
    logic               channel = 1'b0;
    logic [TIMER_W-1:0] capture_value = '0;
    logic               busy;
    logic               done;
    logic               pulse_valid;
    logic [LENGTH_W-1:0] pulse_length;
    logic               pulse_level;
    logic [CNT_W-1:0]   queue_count;

    // Typed expectation travelling with the request, if any.
    logic               req_known = 1'b0;
    pulse_rec_t         req_exp = '0;

    // Predictor state
    logic [TIMER_W-1:0] last_stamp    [CHANNELS];
    logic               level_now     [CHANNELS];
    logic [ENTRY_W-1:0] model_pulses  [CHANNELS][QUEUE_DEPTH];
    logic [PTR_W-1:0]   head          [CHANNELS];
    logic [PTR_W-1:0]   tail          [CHANNELS];
    logic [CNT_W-1:0]   held          [CHANNELS];

    pulse_rec_t         pending_pulses [$];
    logic [TIMER_W-1:0] sent_stamp [CHANNELS];
    int                 mismatches = 0;
    int                 quiet_cycles = 0;

    edge_capture_pulse_queue uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .channel       (channel),
        .capture_value (capture_value),
        .done          (done),
        .pulse_valid   (pulse_valid),
        .pulse_length  (pulse_length),
        .pulse_level   (pulse_level),
        .queue_count   (queue_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic pulse_rec_t capture_queue_step(cmd_t op, logic lane,
                                                      logic [TIMER_W-1:0] stamp);
        pulse_rec_t         rec;
        logic [TIMER_W-1:0] span;
        logic [ENTRY_W-1:0] entry;
        rec = '0;
        if (int'(lane) < CHANNELS)
        begin
            if (op == CMD_CAPTURE)
            begin
                span = stamp - last_stamp[lane];
                if (span > {1'b0, LENGTH_MAX})
                    span = {1'b0, LENGTH_MAX};
                last_stamp[lane] = stamp;
                // drop the pulse when the queue is full, but still advance the level
                if (int'(held[lane]) < QUEUE_DEPTH)
                begin
                    model_pulses[lane][head[lane]] = {level_now[lane], span[LENGTH_W-1:0]};
                    head[lane] = (int'(head[lane]) == QUEUE_DEPTH - 1) ? '0 : head[lane] + 1'b1;
                    held[lane] = held[lane] + 1'b1;
                end
                level_now[lane] = ~level_now[lane];
            end
            else if (held[lane] != '0)
            begin
                entry = model_pulses[lane][tail[lane]];
                tail[lane] = (int'(tail[lane]) == QUEUE_DEPTH - 1) ? '0 : tail[lane] + 1'b1;
                held[lane] = held[lane] - 1'b1;
                rec.valid = 1'b1;
                rec.length = entry[LENGTH_W-1:0];
                rec.level = entry[ENTRY_W-1];
            end
            rec.count = held[lane];
        end
        return rec;
    endfunction

    // Record accepted requests, check results, and watch for a stall.
    always @(posedge clk)
    begin : result_check
        pulse_rec_t want;
        pulse_rec_t got;
        logic       accepted;
        if (rst_n)
        begin
            accepted = start && (busy === 1'b0);
            if (accepted)
            begin
                want = capture_queue_step(cmd, channel, capture_value);
                pending_pulses.push_back(req_known ? req_exp : want);
            end
            if (done === 1'b1)
            begin
                got = '{pulse_valid, pulse_length, pulse_level, queue_count};
                if (pending_pulses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result valid=%b length=%h level=%b count=%0d",
                                 $realtime, got.valid, got.length, got.level, got.count);
                end
                else
                begin
                    want = pending_pulses.pop_front();
                    if (got.valid !== want.valid || got.length !== want.length ||
                        got.level !== want.level || got.count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch valid %b/%b length %h/%h level %b/%b count %0d/%0d",
                                     $realtime, want.valid, got.valid, want.length, got.length,
                                     want.level, got.level, want.count, got.count);
                    end
                end
            end
            quiet_cycles = (accepted || done === 1'b1) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_request(cmd_t op, logic lane, logic [TIMER_W-1:0] stamp,
                                logic known, pulse_rec_t res);
        start <= 1'b1;
        cmd <= op;
        channel <= lane;
        capture_value <= stamp;
        req_known <= known;
        req_exp <= res;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Let the last request reach the queue before waiting on it.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_pulses.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                 pick;
        cmd_t               op;
        logic               lane;
        logic [TIMER_W-1:0] stamp;
        for (int c = 0; c < CHANNELS; c++)
        begin
            last_stamp[c] = '0;
            level_now[c] = 1'b1;
            head[c] = '0;
            tail[c] = '0;
            held[c] = '0;
            sent_stamp[c] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
        begin
            if (i % 7 == 3)
                hold_off($urandom_range(1, MAX_GAP));
            send_request(DIR_TAB[i].req.cmd, DIR_TAB[i].req.channel,
                         DIR_TAB[i].req.capture_value, DIR_TAB[i].known, DIR_TAB[i].res);
        end
        drain_results();
        for (int c = 0; c < CHANNELS; c++)
            sent_stamp[c] = last_stamp[c];

        // Fill and drain each channel in turn so the queues wrap and overflow.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < PHASE_GAP[phase])
                    hold_off($urandom_range(1, MAX_GAP));
                op = ($urandom_range(0, 99) < PHASE_CAP[phase]) ? CMD_CAPTURE : CMD_READ;
                lane = ($urandom_range(0, 99) < PHASE_CH0[phase]) ? 1'b0 : 1'b1;
                stamp = $urandom;
                if (op == CMD_CAPTURE)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        stamp = sent_stamp[lane] + TIMER_W'($urandom_range(1, 16'h7fff));
                    else if (pick < 70)
                        stamp = sent_stamp[lane] + TIMER_W'($urandom_range(0, 20));
                    else if (pick < 82)
                        stamp = sent_stamp[lane] + TIMER_W'($urandom_range(16'h7fff, 16'hffff));
                    else if (pick < 88)
                        stamp = sent_stamp[lane];
                    sent_stamp[lane] = stamp;
                end
                send_request(op, lane, stamp, 1'b0, NO_CHECK);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_pulses.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ecpq_pkg.sv
rtl/ecpq_store.sv
rtl/ecpq_ctrl.sv
rtl/edge_capture_pulse_queue.sv
dv/testbench.sv
